// ----- hw/rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

   // Seven-bit length codes that select an extended length field.
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Index of the last byte of each multi-byte header field, counting from zero.
   localparam logic [2:0] EXT16_LAST_IDX = 3'd1;
   localparam logic [2:0] EXT64_LAST_IDX = 3'd7;
   localparam logic [2:0] KEY_LAST_IDX   = 3'd3;

   // One result item from the parser to the output register.
   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       has_byte;
      logic       frame_end;
   } wsd_result_type;

endpackage

// ----- hw/rtl/wsd_parse.sv -----
// Frame header parser and payload unmasking for the WebSocket frame deframer.
module wsd_parse
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     rx_byte,
   output wsd_result_type result
);

   typedef enum logic [2:0] {
      PH_HEAD0,
      PH_HEAD1,
      PH_EXT16,
      PH_EXT64,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [3:0]             held_opcode_ff, held_opcode_in;
   logic                   mask_on_ff, mask_on_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [2:0]             header_count_ff, header_count_in;
   logic [31:0]            mask_key_ff, mask_key_in;
   logic [1:0]             key_index_ff, key_index_in;

   logic [LENGTH_BITS-1:0] ext_shifted;
   logic [LENGTH_BITS-1:0] bytes_dec;
   logic [2:0]             ext_last;
   logic [7:0]             key_byte;
   logic [6:0]             len_code;

   // Helper values shared by several phases.
   assign len_code    = rx_byte[6:0];
   assign ext_shifted = {bytes_left_ff[LENGTH_BITS-9:0], rx_byte};
   assign bytes_dec   = bytes_left_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   assign ext_last    = (phase_ff == PH_EXT16) ? EXT16_LAST_IDX : EXT64_LAST_IDX;
   // The first key byte sits in the top bits, so index i selects byte 3 - i.
   assign key_byte    = mask_key_ff[{~key_index_ff, 3'b000} +: 8];

   // Next state and result for the byte in the input register.
   always_comb begin
      phase_in        = phase_ff;
      held_opcode_in  = held_opcode_ff;
      mask_on_in      = mask_on_ff;
      bytes_left_in   = bytes_left_ff;
      header_count_in = header_count_ff;
      mask_key_in     = mask_key_ff;
      key_index_in    = key_index_ff;
      result              = '0;
      result.frame_opcode = held_opcode_ff;

      case (phase_ff)
         PH_HEAD1: begin
            mask_on_in      = rx_byte[7];
            header_count_in = '0;
            if (len_code == LEN_CODE_EXT16) begin
               bytes_left_in = '0;
               phase_in      = PH_EXT16;
            end else if (len_code == LEN_CODE_EXT64) begin
               bytes_left_in = '0;
               phase_in      = PH_EXT64;
            end else begin
               bytes_left_in = {{(LENGTH_BITS-7){1'b0}}, len_code};
               if (rx_byte[7]) begin
                  phase_in = PH_KEY;
               end else begin
                  key_index_in = '0;
                  if (len_code == 7'd0) begin
                     phase_in        = PH_HEAD0;
                     result.valid     = 1'b1;
                     result.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_EXT16, PH_EXT64: begin
            bytes_left_in = ext_shifted;
            if (header_count_ff >= ext_last) begin
               // Length is complete: go on to the key or finish the header.
               header_count_in = '0;
               if (mask_on_ff) begin
                  phase_in = PH_KEY;
               end else begin
                  key_index_in = '0;
                  if (ext_shifted == '0) begin
                     phase_in        = PH_HEAD0;
                     result.valid     = 1'b1;
                     result.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end else begin
               header_count_in = header_count_ff + 3'd1;
            end
         end
         PH_KEY: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            if (header_count_ff >= KEY_LAST_IDX) begin
               header_count_in = '0;
               key_index_in    = '0;
               if (bytes_left_ff == '0) begin
                  phase_in        = PH_HEAD0;
                  result.valid     = 1'b1;
                  result.frame_end = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               header_count_in = header_count_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            key_index_in        = key_index_ff + 2'd1;
            bytes_left_in       = bytes_dec;
            result.valid        = 1'b1;
            result.has_byte     = 1'b1;
            result.payload_byte = mask_on_ff ? (rx_byte ^ key_byte) : rx_byte;
            if (bytes_dec == '0) begin
               phase_in         = PH_HEAD0;
               result.frame_end = 1'b1;
            end
         end
         default: begin
            // First header byte: take the opcode and clear the frame state.
            held_opcode_in  = rx_byte[3:0];
            mask_on_in      = 1'b0;
            bytes_left_in   = '0;
            header_count_in = '0;
            mask_key_in     = '0;
            key_index_in    = '0;
            phase_in        = PH_HEAD1;
         end
      endcase
   end

   // Frame state registers, updated once per byte taken from the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEAD0;
         held_opcode_ff  <= '0;
         mask_on_ff      <= 1'b0;
         bytes_left_ff   <= '0;
         header_count_ff <= '0;
         mask_key_ff     <= '0;
         key_index_ff    <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         held_opcode_ff  <= held_opcode_in;
         mask_on_ff      <= mask_on_in;
         bytes_left_ff   <= bytes_left_in;
         header_count_ff <= header_count_in;
         mask_key_ff     <= mask_key_in;
         key_index_ff    <= key_index_in;
      end
   end

endmodule

// ----- hw/rtl/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
// Usage: received stream bytes enter on the req_ channel, one byte per item in
// req_tdata. Payload bytes leave on the rsp_ channel, unmasked, with the frame
// opcode and a data-present flag in rsp_tuser and rsp_tlast on the last item
// of a frame. A frame of length zero gives one item with the flag clear and
// rsp_tdata zero at its final header byte; other header bytes give no item.
// An accepted byte waits in the input register, and its result item in the result register that drives rsp_.
// Throughput is one byte per cycle: the input register feeds the parser and
// the result register in the same cycle, and each stage advances whenever the
// result register is empty or being emptied.
// When the receiver holds rsp_tready low, the result register keeps its item,
// the input register holds one more byte and req_tready then drops.
// Reset (synchronous, active high) empties both registers and returns the
// parser to waiting for the first header byte of a frame.
module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [4:0] rsp_tuser,   // [3:0] frame_opcode, [4] has_byte
   output logic       rsp_tlast
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           out_valid_ff, out_valid_in;
   wsd_result_type out_item_ff, out_item_in;
   wsd_result_type parse_result;
   logic           advance;
   logic           step;

   // Handshake: the pipeline moves when the result register can take an item.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   wsd_parse #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (parse_result)
   );

   // Next values of the input and result registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
      if (advance) begin
         out_valid_in = step && parse_result.valid;
         out_item_in  = parse_result;
      end
   end

   // Control bits take reset; the payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_item_ff <= out_item_in;
   end

   // Result channel outputs.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_item_ff.payload_byte;
   assign rsp_tuser  = {out_item_ff.has_byte, out_item_ff.frame_opcode};
   assign rsp_tlast  = out_item_ff.frame_end;

endmodule

// ----- tb/websocket_frame_deframer_tb.sv -----
// Self-checking testbench for the WebSocket frame deframer on its byte streams.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
   import wsd_pkg::*;

   localparam int LEN_BITS = 64;

   // Parser phases of the predictor.
   typedef enum logic [2:0] {
      ST_HEAD0,
      ST_HEAD1,
      ST_EXT16,
      ST_EXT64,
      ST_KEY,
      ST_PAYLOAD
   } parse_state_type;

   // Length field forms a generated frame can use.
   typedef enum int {
      FORM_SHORT,
      FORM_EXT16,
      FORM_EXT64
   } length_form_type;

   // One expected result item.
   typedef struct packed {
      logic [7:0] data;
      logic [3:0] opcode;
      logic       has_byte;
      logic       frame_end;
   } payload_item_type;

   // Tracks the frame parse of the accepted byte stream and checks the unmasked payload.
   class payload_tracker_type;
      parse_state_type       parse_state = ST_HEAD0;
      logic [3:0]            cur_opcode  = '0;
      logic                  cur_masked  = 1'b0;
      logic [LEN_BITS-1:0]   bytes_left  = '0;
      logic [2:0]            hdr_count   = '0;
      logic [31:0]           key_word    = '0;
      logic [1:0]            key_pos     = '0;
      payload_item_type      expected_payload[$];
      int                    errors      = 0;

      task flag_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      function int pending();
         return expected_payload.size();
      endfunction

      // Appends one expected item at the tail of the queue.
      function void add_expected(payload_item_type item);
         expected_payload.insert(expected_payload.size(), item);
      endfunction

      // Length and key are known: either close an empty frame or start the payload.
      function void finish_header();
         payload_item_type item;
         key_pos   = '0;
         hdr_count = '0;
         if (bytes_left == 0) begin
            parse_state = ST_HEAD0;
            item = '{data: 8'h00, opcode: cur_opcode, has_byte: 1'b0, frame_end: 1'b1};
            add_expected(item);
         end else begin
            parse_state = ST_PAYLOAD;
         end
      endfunction

      function void finish_length();
         hdr_count = '0;
         if (cur_masked) begin
            parse_state = ST_KEY;
         end else begin
            finish_header();
         end
      endfunction

      // Advances the parse by one accepted byte.
      function void accept_byte(logic [7:0] b);
         logic [6:0]       code;
         logic [7:0]       data;
         logic [31:0]      shifted;
         logic [2:0]       last_idx;
         payload_item_type item;
         case (parse_state)
            ST_HEAD1: begin
               cur_masked = b[7];
               code       = b[6:0];
               bytes_left = '0;
               hdr_count  = '0;
               if (code == LEN_CODE_EXT16) begin
                  parse_state = ST_EXT16;
               end else if (code == LEN_CODE_EXT64) begin
                  parse_state = ST_EXT64;
               end else begin
                  bytes_left = LEN_BITS'(code);
                  finish_length();
               end
            end
            ST_EXT16, ST_EXT64: begin
               bytes_left = (bytes_left << 8) | LEN_BITS'(b);
               last_idx   = (parse_state == ST_EXT16) ? EXT16_LAST_IDX : EXT64_LAST_IDX;
               if (hdr_count >= last_idx) begin
                  finish_length();
               end else begin
                  hdr_count = hdr_count + 3'd1;
               end
            end
            ST_KEY: begin
               key_word = {key_word[23:0], b};
               if (hdr_count >= KEY_LAST_IDX) begin
                  finish_header();
               end else begin
                  hdr_count = hdr_count + 3'd1;
               end
            end
            ST_PAYLOAD: begin
               data = b;
               if (cur_masked) begin
                  shifted = key_word >> (24 - 8 * key_pos);
                  data    = data ^ shifted[7:0];
               end
               key_pos    = key_pos + 2'd1;
               bytes_left = bytes_left - 1'b1;
               item = '{data: data, opcode: cur_opcode, has_byte: 1'b1,
                        frame_end: (bytes_left == 0)};
               add_expected(item);
               if (bytes_left == 0) begin
                  parse_state = ST_HEAD0;
               end
            end
            default: begin
               cur_opcode  = b[3:0];
               cur_masked  = 1'b0;
               bytes_left  = '0;
               hdr_count   = '0;
               key_word    = '0;
               key_pos     = '0;
               parse_state = ST_HEAD1;
            end
         endcase
      endfunction

      // Compares one accepted result item with the oldest expectation.
      task check_payload(logic [7:0] data, logic [4:0] user, logic last);
         payload_item_type want;
         if (expected_payload.size() == 0) begin
            flag_mismatch($sformatf("unexpected item data=%02h user=%02h last=%0b",
                                    data, user, last));
         end else begin
            want = expected_payload.pop_front();
            if (data !== want.data) begin
               flag_mismatch($sformatf("payload byte %02h, expected %02h", data, want.data));
            end
            if (user[3:0] !== want.opcode) begin
               flag_mismatch($sformatf("opcode %0h, expected %0h", user[3:0], want.opcode));
            end
            if (user[4] !== want.has_byte) begin
               flag_mismatch($sformatf("has_byte %0b, expected %0b", user[4], want.has_byte));
            end
            if (last !== want.frame_end) begin
               flag_mismatch($sformatf("frame end %0b, expected %0b", last, want.frame_end));
            end
         end
      endtask
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] payload_byte
   logic [4:0] rsp_tuser;            // [3:0] frame_opcode, [4] has_byte
   logic       rsp_tlast;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int bytes_sent  = 0;

   payload_tracker_type tracker = new();

   websocket_frame_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Receiver back-pressure at the current idle rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Check every result item taken by the receiver.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_payload(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Offers one byte, with random idle cycles ahead of it, and waits for acceptance.
   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do begin
         @(posedge clock);
      end while (!req_tready);
      tracker.accept_byte(b);
      bytes_sent++;
   endtask

   // Sends one complete frame with random payload bytes.
   task send_frame(input logic [3:0] opcode, input logic [3:0] top_bits,
                   input length_form_type form, input logic masked,
                   input logic [63:0] length, input logic [31:0] key);
      logic [6:0] code;
      case (form)
         FORM_EXT16: code = LEN_CODE_EXT16;
         FORM_EXT64: code = LEN_CODE_EXT64;
         default:    code = length[6:0];
      endcase
      send_byte({top_bits, opcode});
      send_byte({masked, code});
      if (form == FORM_EXT16) begin
         for (int i = 1; i >= 0; i--) send_byte(length[8*i +: 8]);
      end else if (form == FORM_EXT64) begin
         for (int i = 7; i >= 0; i--) send_byte(length[8*i +: 8]);
      end
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
      end
      for (longint n = 0; n < length; n++) send_byte(8'($urandom_range(255)));
   endtask

   // Random frames, mostly short, until the byte budget is used.
   task send_random_frames(input int budget);
      int              stop_at;
      int              sel;
      logic [63:0]     length;
      length_form_type form;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 10) begin
            length = 0;
         end else if (sel < 70) begin
            length = $urandom_range(8, 1);
         end else if (sel < 95) begin
            length = $urandom_range(125, 9);
         end else begin
            length = $urandom_range(300, 126);
         end
         // Longer lengths need an extended field; short ones sometimes use one anyway.
         sel = $urandom_range(9);
         if (length > 125) begin
            form = (sel < 7) ? FORM_EXT16 : FORM_EXT64;
         end else if (sel < 7) begin
            form = FORM_SHORT;
         end else if (sel < 9) begin
            form = FORM_EXT16;
         end else begin
            form = FORM_EXT64;
         end
         send_frame(4'($urandom_range(15)), 4'($urandom_range(15)), form,
                    1'($urandom_range(1)), length, $urandom());
      end
   endtask

   task wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin
      #4_000_000;
      $display("websocket_frame_deframer_tb failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames: empty short frame, full-scale masked byte,
      // empty frames closing on an extended length byte and on a key byte.
      send_frame(4'h0, 4'h0, FORM_SHORT, 1'b0, 64'd0, 32'h0);
      send_frame(4'hF, 4'hF, FORM_SHORT, 1'b1, 64'd1, 32'hFFFF_FFFF);
      send_frame(4'h1, 4'h8, FORM_EXT16, 1'b0, 64'd0, 32'h0);
      send_frame(4'h9, 4'h8, FORM_EXT64, 1'b1, 64'd0, 32'hA5C3_3C5A);

      // Slow sender, slower receiver.
      tx_idle_pct = 34;
      rx_idle_pct = 76;
      send_random_frames(560);

      // Hold off until the output side has caught up.
      req_tvalid <= 1'b0;
      wait_drained();

      tx_idle_pct = 76;
      rx_idle_pct = 34;
      send_random_frames(560);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random_frames(600);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.flag_mismatch($sformatf("%0d result items never arrived", tracker.pending()));
      end
      if (tracker.errors == 0) begin
         $display("websocket_frame_deframer_tb passed");
      end else begin
         $display("websocket_frame_deframer_tb failed");
      end
      $finish;
   end

endmodule
